// ===== rtl/aalu_pkg.sv =====
// ----------------------------------------------------------------------------
// aalu_pkg - shared types and constants of the accumulator ALU
// Widths, operation codes and status flag positions used by the interfaces
// and the top level.
// ----------------------------------------------------------------------------
package aalu_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned OP_W   = 4;

  // Status byte bit positions.
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  typedef logic [DATA_W-1:0] byte_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADC     = 4'd0,
    OP_SBC     = 4'd1,
    OP_AND     = 4'd2,
    OP_ORA     = 4'd3,
    OP_EOR     = 4'd4,
    OP_BIT     = 4'd5,
    OP_ASL     = 4'd6,
    OP_LSR     = 4'd7,
    OP_ROL     = 4'd8,
    OP_ROR     = 4'd9,
    OP_ROL_ACC = 4'd10,
    OP_ROR_ACC = 4'd11,
    OP_INC     = 4'd12,
    OP_DEC     = 4'd13
  } op_t;

endpackage

// ===== rtl/aalu_if.sv =====
// ----------------------------------------------------------------------------
// aalu_if - item channels of the accumulator ALU
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface aalu_op_if;
  logic                          valid;
  logic                          ready;
  logic [aalu_pkg::OP_W-1:0]     op;
  logic [aalu_pkg::DATA_W-1:0]   operand;

  modport source (output valid, output op, output operand, input ready);
  modport sink   (input valid, input op, input operand, output ready);
endinterface

interface aalu_res_if;
  logic                          valid;
  logic                          ready;
  logic [aalu_pkg::DATA_W-1:0]   result_byte;
  logic [aalu_pkg::DATA_W-1:0]   accumulator_out;
  logic [aalu_pkg::DATA_W-1:0]   status_out;

  modport source (output valid, output result_byte, output accumulator_out,
                  output status_out, input ready);
  modport sink   (input valid, input result_byte, input accumulator_out,
                  input status_out, output ready);
endinterface

// ===== rtl/accumulator_alu_with_status_flags_unit.sv =====
// ----------------------------------------------------------------------------
// accumulator_alu_with_status_flags_unit - 8-bit accumulator ALU
// An ALU in the manner of the classic 8-bit microprocessors, binary mode only,
// holding an accumulator and a status byte.
//
// Each accepted item carries an operation code and an operand byte and
// produces exactly one result item holding the result byte, the accumulator
// and the status byte as they stand after the operation. An item is first
// captured in an input register; once the output register is free or being
// emptied, the ALU works on it against the current accumulator and status,
// writes both back and loads the output register. While results are taken,
// one item is accepted every cycle: the only loop is the accumulator and
// status write-back, so consecutive items see each other's results without
// any wait. The input register can still take an item while a finished
// result waits in the output register, and both stages stall together only
// when the output is held and the input stage is full.
// Status bits other than carry, zero, overflow and negative pass through
// untouched, and the unused codes 14 and 15 leave all state alone and return
// the accumulator.
// ----------------------------------------------------------------------------
module accumulator_alu_with_status_flags_unit (
  input  logic           clk,
  input  logic           rst_n,
  aalu_op_if.sink        in_ch,
  aalu_res_if.source     out_ch
);

  // Input register stage.
  logic                      s1_valid_r;
  logic [aalu_pkg::OP_W-1:0] op_r;
  aalu_pkg::byte_t           operand_r;

  // Architectural state.
  aalu_pkg::byte_t acc_r, acc_nxt;
  aalu_pkg::byte_t st_r,  st_nxt;

  // Output register stage.
  logic            out_valid_r;
  aalu_pkg::byte_t res_r, res_nxt;

  logic advance;
  logic cin;
  logic [aalu_pkg::DATA_W:0] sum;

  // The input stage moves on whenever the output register is free or is
  // being emptied in this cycle.
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  assign cin = st_r[aalu_pkg::FLAG_C];

  // Add and subtract share one adder: subtraction adds the inverted operand,
  // so carry out set means no borrow.
  always_comb begin
    if (op_r == aalu_pkg::OP_SBC) begin
      sum = {1'b0, acc_r} + {1'b0, ~operand_r} + {{aalu_pkg::DATA_W{1'b0}}, cin};
    end else begin
      sum = {1'b0, acc_r} + {1'b0, operand_r} + {{aalu_pkg::DATA_W{1'b0}}, cin};
    end
  end

  always_comb begin
    logic set_zn;
    set_zn  = 1'b1;
    acc_nxt = acc_r;
    st_nxt  = st_r;
    res_nxt = acc_r;
    case (op_r)
      aalu_pkg::OP_ADC: begin
        res_nxt = sum[aalu_pkg::DATA_W-1:0];
        acc_nxt = res_nxt;
        st_nxt[aalu_pkg::FLAG_C] = sum[aalu_pkg::DATA_W];
        st_nxt[aalu_pkg::FLAG_V] = ~(acc_r[7] ^ operand_r[7]) & (acc_r[7] ^ res_nxt[7]);
      end
      aalu_pkg::OP_SBC: begin
        res_nxt = sum[aalu_pkg::DATA_W-1:0];
        acc_nxt = res_nxt;
        st_nxt[aalu_pkg::FLAG_C] = sum[aalu_pkg::DATA_W];
        st_nxt[aalu_pkg::FLAG_V] = (acc_r[7] ^ res_nxt[7]) & (acc_r[7] ^ operand_r[7]);
      end
      aalu_pkg::OP_AND: begin
        res_nxt = acc_r & operand_r;
        acc_nxt = res_nxt;
      end
      aalu_pkg::OP_ORA: begin
        res_nxt = acc_r | operand_r;
        acc_nxt = res_nxt;
      end
      aalu_pkg::OP_EOR: begin
        res_nxt = acc_r ^ operand_r;
        acc_nxt = res_nxt;
      end
      aalu_pkg::OP_BIT: begin
        // Zero comes from the masked accumulator, the other two flags
        // straight from the operand.
        set_zn = 1'b0;
        st_nxt[aalu_pkg::FLAG_Z] = ((acc_r & operand_r) == '0);
        st_nxt[aalu_pkg::FLAG_N] = operand_r[7];
        st_nxt[aalu_pkg::FLAG_V] = operand_r[6];
      end
      aalu_pkg::OP_ASL: begin
        st_nxt[aalu_pkg::FLAG_C] = operand_r[7];
        res_nxt = {operand_r[6:0], 1'b0};
      end
      aalu_pkg::OP_LSR: begin
        st_nxt[aalu_pkg::FLAG_C] = operand_r[0];
        res_nxt = {1'b0, operand_r[7:1]};
      end
      aalu_pkg::OP_ROL: begin
        st_nxt[aalu_pkg::FLAG_C] = operand_r[7];
        res_nxt = {operand_r[6:0], cin};
      end
      aalu_pkg::OP_ROR: begin
        st_nxt[aalu_pkg::FLAG_C] = operand_r[0];
        res_nxt = {cin, operand_r[7:1]};
      end
      aalu_pkg::OP_ROL_ACC: begin
        st_nxt[aalu_pkg::FLAG_C] = acc_r[7];
        res_nxt = {acc_r[6:0], cin};
        acc_nxt = res_nxt;
      end
      aalu_pkg::OP_ROR_ACC: begin
        st_nxt[aalu_pkg::FLAG_C] = acc_r[0];
        res_nxt = {cin, acc_r[7:1]};
        acc_nxt = res_nxt;
      end
      aalu_pkg::OP_INC: begin
        res_nxt = operand_r + aalu_pkg::DATA_W'(1);
      end
      aalu_pkg::OP_DEC: begin
        res_nxt = operand_r - aalu_pkg::DATA_W'(1);
      end
      default: begin
        // Unused codes: no operation.
        set_zn = 1'b0;
      end
    endcase
    if (set_zn) begin
      st_nxt[aalu_pkg::FLAG_Z] = (res_nxt == '0);
      st_nxt[aalu_pkg::FLAG_N] = res_nxt[7];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      st_r        <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        acc_r       <= acc_nxt;
        st_r        <= st_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      op_r      <= in_ch.op;
      operand_r <= in_ch.operand;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.result_byte     = res_r;
  assign out_ch.accumulator_out = acc_r;
  assign out_ch.status_out      = st_r;

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - self-checking testbench of the 8-bit accumulator ALU
// Drives operation items into the ALU and checks every result item (result
// byte, accumulator and status byte) against a cycle-free prediction of the
// ALU. The prediction keeps its own accumulator and status byte. A short
// directed part comes first, then random items with random idling on both
// channels, and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  // The two codes above the last operation are spare and act as no-ops.
  localparam logic [aalu_pkg::OP_W-1:0] OP_SPARE_LO = 4'd14;
  localparam logic [aalu_pkg::OP_W-1:0] OP_SPARE_HI = 4'd15;

  // Cycles without any handshake before the run is declared hung. The
  // slowest correct run stalls for at most a sender gap plus a receiver
  // stall plus the trip through both stages, so this is far beyond any real wait.
  localparam int STALL_LIMIT  = 2000;
  // Cycles left to run once nothing is outstanding, to catch stray results.
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_LIMIT  = 100;

  typedef struct packed {
    aalu_pkg::byte_t result_byte;
    aalu_pkg::byte_t accumulator;
    aalu_pkg::byte_t status;
  } alu_result_t;

  logic clk;
  logic rst_n;

  aalu_op_if  op_ch ();
  aalu_res_if res_ch ();

  accumulator_alu_with_status_flags_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (op_ch),
    .out_ch (res_ch)
  );

  // Shadow copies of the ALU state, advanced once for every accepted item.
  aalu_pkg::byte_t acc_shadow;
  aalu_pkg::byte_t status_shadow;

  // Results that the ALU still owes, oldest first.
  alu_result_t pending_results[$];

  int  mismatches;
  int  results_seen;
  int  stall_cycles;
  bit  sender_idling;
  bit  receiver_idling;
  int  receiver_hold;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // Works out the result item that one operation item causes and advances
  // the shadow accumulator and status byte. Only carry, zero, overflow and
  // negative are ever touched; all other status bits keep their value.
  // --------------------------------------------------------------------------
  function automatic alu_result_t predict_alu(input logic [aalu_pkg::OP_W-1:0] op,
                                              input aalu_pkg::byte_t v);
    aalu_pkg::byte_t              a;
    aalu_pkg::byte_t              st;
    aalu_pkg::byte_t              res;
    logic                         cin;
    logic [aalu_pkg::DATA_W:0]    wide;
    alu_result_t                  r;
    a   = acc_shadow;
    st  = status_shadow;
    cin = st[aalu_pkg::FLAG_C];
    res = a;
    case (op)
      aalu_pkg::OP_ADC: begin
        wide                  = {1'b0, a} + {1'b0, v} + cin;
        res                   = wide[aalu_pkg::DATA_W-1:0];
        st[aalu_pkg::FLAG_C]  = wide[aalu_pkg::DATA_W];
        // Overflow when both inputs share a sign that the sum does not.
        st[aalu_pkg::FLAG_V]  = ~(a[7] ^ v[7]) & (a[7] ^ res[7]);
        a                     = res;
      end
      aalu_pkg::OP_SBC: begin
        // A clear carry means a borrow is pending; the top bit of the wide
        // difference is set exactly when the subtraction goes negative.
        wide                  = {1'b0, a} - {1'b0, v}
                                - {{aalu_pkg::DATA_W{1'b0}}, ~cin};
        res                   = wide[aalu_pkg::DATA_W-1:0];
        st[aalu_pkg::FLAG_C]  = ~wide[aalu_pkg::DATA_W];
        st[aalu_pkg::FLAG_V]  = (a[7] ^ res[7]) & (a[7] ^ v[7]);
        a                     = res;
      end
      aalu_pkg::OP_AND: begin
        a   = a & v;
        res = a;
      end
      aalu_pkg::OP_ORA: begin
        a   = a | v;
        res = a;
      end
      aalu_pkg::OP_EOR: begin
        a   = a ^ v;
        res = a;
      end
      aalu_pkg::OP_BIT: begin
        // The accumulator is only tested; overflow and negative are copied
        // straight from the operand.
        st[aalu_pkg::FLAG_Z] = ((a & v) == '0);
        st[aalu_pkg::FLAG_N] = v[7];
        st[aalu_pkg::FLAG_V] = v[6];
      end
      aalu_pkg::OP_ASL: begin
        st[aalu_pkg::FLAG_C] = v[7];
        res                  = {v[6:0], 1'b0};
      end
      aalu_pkg::OP_LSR: begin
        st[aalu_pkg::FLAG_C] = v[0];
        res                  = {1'b0, v[7:1]};
      end
      aalu_pkg::OP_ROL: begin
        st[aalu_pkg::FLAG_C] = v[7];
        res                  = {v[6:0], cin};
      end
      aalu_pkg::OP_ROR: begin
        st[aalu_pkg::FLAG_C] = v[0];
        res                  = {cin, v[7:1]};
      end
      aalu_pkg::OP_ROL_ACC: begin
        st[aalu_pkg::FLAG_C] = a[7];
        a                    = {a[6:0], cin};
        res                  = a;
      end
      aalu_pkg::OP_ROR_ACC: begin
        st[aalu_pkg::FLAG_C] = a[0];
        a                    = {cin, a[7:1]};
        res                  = a;
      end
      aalu_pkg::OP_INC: res = v + 8'd1;
      aalu_pkg::OP_DEC: res = v - 8'd1;
      default: ;
    endcase
    // Zero and negative follow the result byte for every real operation
    // except the bit test, which has set them itself above.
    if (!(op inside {aalu_pkg::OP_BIT, OP_SPARE_LO, OP_SPARE_HI})) begin
      st[aalu_pkg::FLAG_Z] = (res == '0);
      st[aalu_pkg::FLAG_N] = res[7];
    end
    acc_shadow    = a;
    status_shadow = st;
    r.result_byte = res;
    r.accumulator = a;
    r.status      = st;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Failure reporting: one line per failure, with printing capped so that a
  // badly broken design cannot flood the log.
  // --------------------------------------------------------------------------
  task automatic report_failure(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  task automatic compare_field(input string field, input aalu_pkg::byte_t want,
                               input aalu_pkg::byte_t got);
    if (want !== got) begin
      report_failure($sformatf("result %0d: %s expected %02h, got %02h",
                               results_seen, field, want, got));
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking and watchdog
  // Both channels are sampled at the rising edge, before the design's
  // registers update. An accepted operation item is predicted at once; an
  // accepted result item is compared with the oldest prediction waiting.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    alu_result_t want;
    bit          moved;
    if (rst_n) begin
      moved = 1'b0;
      if (op_ch.valid && op_ch.ready) begin
        pending_results.push_back(predict_alu(op_ch.op, op_ch.operand));
        moved = 1'b1;
      end
      if (res_ch.valid && res_ch.ready) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          report_failure($sformatf("result %0d arrived with no item outstanding",
                                   results_seen));
        end else begin
          want = pending_results.pop_front();
          compare_field("result_byte", want.result_byte, res_ch.result_byte);
          compare_field("accumulator_out", want.accumulator,
                        res_ch.accumulator_out);
          compare_field("status_out", want.status, res_ch.status_out);
        end
        results_seen++;
      end
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("watchdog expired with %0d results outstanding",
                   pending_results.size());
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result channel back-pressure
  // While idling is enabled the receiver drops ready for bursts of random
  // length; between bursts it takes results at full rate.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      res_ch.ready  <= 1'b0;
      receiver_hold <= 0;
    end else if (receiver_hold > 0) begin
      res_ch.ready  <= 1'b0;
      receiver_hold <= receiver_hold - 1;
    end else if (receiver_idling && $urandom_range(0, 7) == 0) begin
      res_ch.ready  <= 1'b0;
      receiver_hold <= $urandom_range(0, 7);
    end else begin
      res_ch.ready  <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Sending one item
  // Inputs change only at the falling edge. Valid is left high after the
  // handshake so that back-to-back items keep it high without a glitch; the
  // next call either presents a new item or starts an idle burst.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [aalu_pkg::OP_W-1:0] op,
                           input aalu_pkg::byte_t operand);
    int gap;
    @(negedge clk);
    if (sender_idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      op_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    op_ch.valid   <= 1'b1;
    op_ch.op      <= op;
    op_ch.operand <= operand;
    @(posedge clk);
    while (!op_ch.ready) @(posedge clk);
  endtask

  // Operands lean towards the byte boundaries where the flags change.
  function automatic aalu_pkg::byte_t pick_operand();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'h7F;
      3:       return 8'h80;
      4:       return 8'hFF;
      default: return aalu_pkg::byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Add and subtract across the carry and overflow boundaries, starting from
  // the reset state of a zero accumulator and a clear carry.
  task automatic test_arithmetic_edges();
    send_item(aalu_pkg::OP_ADC, 8'hFF);  // 00 + FF: no carry, negative
    send_item(aalu_pkg::OP_ADC, 8'h01);  // FF + 01: wraps to zero with carry out
    send_item(aalu_pkg::OP_ADC, 8'h7E);  // 00 + 7E + carry: 7F
    send_item(aalu_pkg::OP_ADC, 8'h01);  // 7F + 01: signed overflow into negative
    send_item(aalu_pkg::OP_SBC, 8'h01);  // borrow pending, 80 - 01 - 1: overflow back
    send_item(aalu_pkg::OP_SBC, 8'hFF);  // operand above accumulator: borrow out
    send_item(aalu_pkg::OP_SBC, 8'h00);  // borrow in with zero operand
    send_item(aalu_pkg::OP_SBC, 8'h80);  // subtract the most negative byte
  endtask

  // Logic operations and the bit test, including the bit test's own flags.
  task automatic test_logic_and_bit();
    send_item(aalu_pkg::OP_ORA, 8'hFF);
    send_item(aalu_pkg::OP_AND, 8'hC0);
    send_item(aalu_pkg::OP_BIT, 8'h40);  // overlap present, overflow from operand
    send_item(aalu_pkg::OP_BIT, 8'h3F);  // no overlap: zero set, negative clear
    send_item(aalu_pkg::OP_BIT, 8'h80);
    send_item(aalu_pkg::OP_EOR, 8'hC0);  // clears the accumulator
    send_item(aalu_pkg::OP_AND, 8'h00);
  endtask

  // Operand shifts and rotates, accumulator rotates, increment, decrement
  // and the low spare code, which must leave all state alone.
  task automatic test_shift_rotate_step();
    send_item(aalu_pkg::OP_ASL, 8'h80);  // carry out, zero result
    send_item(aalu_pkg::OP_ROL, 8'hFF);  // carry in shifted into bit 0
    send_item(aalu_pkg::OP_LSR, 8'h01);
    send_item(aalu_pkg::OP_ROR, 8'h01);  // carry into bit 7
    send_item(aalu_pkg::OP_ORA, 8'h81);
    send_item(aalu_pkg::OP_ROL_ACC, 8'h00);
    send_item(aalu_pkg::OP_ROR_ACC, 8'hFF);
    send_item(aalu_pkg::OP_INC, 8'hFF);  // wraps to zero
    send_item(aalu_pkg::OP_DEC, 8'h00);  // wraps to FF
    send_item(OP_SPARE_LO, 8'hA5);
  endtask

  // --------------------------------------------------------------------------
  // Random tests
  // --------------------------------------------------------------------------

  // Every code, spare ones included, with random operands.
  task automatic test_random_ops(input int count);
    repeat (count) begin
      send_item(aalu_pkg::OP_W'($urandom_range(int'(aalu_pkg::OP_ADC),
                                               int'(OP_SPARE_HI))),
                pick_operand());
    end
  endtask

  // Long runs of add and subtract so that carry and the accumulator are
  // handed from item to item, with accumulator rotates mixed in to move the
  // carry through the accumulator and back.
  task automatic test_carry_chains(input int count);
    logic [aalu_pkg::OP_W-1:0] op;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: op = aalu_pkg::OP_ADC;
        4, 5, 6:    op = aalu_pkg::OP_SBC;
        7:          op = aalu_pkg::OP_ROL_ACC;
        8:          op = aalu_pkg::OP_ROR_ACC;
        default:    op = aalu_pkg::OP_W'($urandom_range(int'(aalu_pkg::OP_ADC),
                                                        int'(OP_SPARE_HI)));
      endcase
      send_item(op, pick_operand());
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    op_ch.valid     = 1'b0;
    op_ch.op        = aalu_pkg::OP_ADC;
    op_ch.operand   = '0;
    res_ch.ready    = 1'b0;
    acc_shadow      = '0;
    status_shadow   = '0;
    mismatches      = 0;
    results_seen    = 0;
    stall_cycles    = 0;
    sender_idling   = 1'b0;
    receiver_idling = 1'b0;
    receiver_hold   = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The arithmetic edges run at full rate; from the logic tests on, both
    // sides idle at random so that the directed cases also meet stalls.
    test_arithmetic_edges();
    sender_idling   = 1'b1;
    receiver_idling = 1'b1;
    test_logic_and_bit();
    test_shift_rotate_step();

    test_random_ops(600);
    test_carry_chains(500);

    // The last stretch has no idling on either side.
    sender_idling   = 1'b0;
    receiver_idling = 1'b0;
    test_random_ops(325);
    test_carry_chains(300);

    @(negedge clk);
    op_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== accumulator_alu_with_status_flags_unit.f =====
rtl/aalu_pkg.sv
rtl/aalu_if.sv
rtl/accumulator_alu_with_status_flags_unit.sv
test/tb_top.sv
